>>> hdl/sio_pkg.sv
// Shared types, register map codes and helper functions for the sound and I/O
// timer/interrupt/keyboard block. No dependencies.
`default_nettype none
package sio_pkg;

  localparam int unsigned NUM_TIMERS = 3;
  localparam int unsigned LFSR_W     = 17;
  localparam int unsigned TIMER_W    = 9;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [2:0] SERIAL_DELAY_TICKS = 3'd4;
  localparam logic [7:0] POT_ABSENT         = 8'd228;
  localparam logic [7:0] STATUS_IDLE        = 8'hFF;
  localparam logic [7:0] STATUS_RESET_BITS  = 8'hE0;

  localparam int unsigned PEND_BREAK   = 7;
  localparam int unsigned PEND_KEY     = 6;
  localparam int unsigned PEND_SEROUT  = 4;
  localparam int unsigned PEND_SERDONE = 3;

  localparam int unsigned STAT_KEY_DOWN = 2;
  localparam int unsigned STAT_SHIFT    = 3;
  localparam int unsigned KEY_SHIFT_BIT = 6;

  typedef enum logic [2:0] {
    OP_READ     = 3'd0,
    OP_WRITE    = 3'd1,
    OP_TICK     = 3'd2,
    OP_KEY_DOWN = 3'd3,
    OP_KEY_UP   = 3'd4,
    OP_BREAK    = 3'd5
  } opcode_e;

  localparam logic [3:0] ADDR_AUDIO_CTRL = 4'd8;
  localparam logic [3:0] ADDR_KEY_CODE   = 4'd9;
  localparam logic [3:0] ADDR_RANDOM     = 4'd10;
  localparam logic [3:0] ADDR_SEROUT     = 4'd13;
  localparam logic [3:0] ADDR_IRQ        = 4'd14;
  localparam logic [3:0] ADDR_SERIAL     = 4'd15;
  // write-side names for shared addresses
  localparam logic [3:0] ADDR_TIMER_RST  = 4'd9;
  localparam logic [3:0] ADDR_STAT_RST   = 4'd10;

  // frequency register feeding each timer
  localparam logic [1:0] TIMER_FREQ_IDX [NUM_TIMERS] = '{2'd0, 2'd1, 2'd3};

  typedef struct packed {
    logic [7:0] data_in;
    logic [3:0] reg_addr;
    logic [2:0] opcode;
  } item_t;

  typedef struct packed {
    logic [7:0] pending_flags;
    logic [7:0] read_data;
  } result_t;

  function automatic logic [TIMER_W-1:0] reload_value(input logic [7:0] freq);
    logic [TIMER_W-1:0] v;
    v = {1'b0, freq} + {{(TIMER_W-1){1'b0}}, 1'b1};
    if (freq == 8'd0) v = TIMER_W'(2);
    return v;
  endfunction

  // eight XNOR feedback steps, taps 16 and 11
  function automatic logic [LFSR_W-1:0] lfsr_step8(input logic [LFSR_W-1:0] s_in);
    logic [LFSR_W-1:0] s;
    s = s_in;
    for (int i = 0; i < 8; i++) begin
      s = {s[LFSR_W-2:0], ~(s[16] ^ s[11])};
    end
    return s;
  endfunction

endpackage
`default_nettype wire

>>> hdl/sio_core.sv
// Register state and single-step logic: decodes one item against the current
// state, gives its result and updates the state on step_i. Uses sio_pkg.
`default_nettype none
module sio_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire sio_pkg::item_t  item_i,
  output sio_pkg::result_t     result_o
);

  logic [7:0] freq_q [4];
  logic [7:0] freq_d [4];
  logic [7:0] chan_ctrl_q [4];
  logic [7:0] chan_ctrl_d [4];
  logic [7:0] audio_ctrl_q, audio_ctrl_d;
  logic [7:0] serial_ctrl_q, serial_ctrl_d;
  logic [7:0] irq_enable_q, irq_enable_d;
  logic [7:0] irq_pend_q, irq_pend_d;
  logic [7:0] status_q, status_d;
  logic [7:0] key_code_q, key_code_d;
  logic [7:0] serout_q, serout_d;
  logic [2:0] delay_q, delay_d;
  logic [sio_pkg::TIMER_W-1:0] timer_q [sio_pkg::NUM_TIMERS];
  logic [sio_pkg::TIMER_W-1:0] timer_d [sio_pkg::NUM_TIMERS];
  logic [sio_pkg::TIMER_W-1:0] reload  [sio_pkg::NUM_TIMERS];
  logic [sio_pkg::TIMER_W-1:0] cnt_pre [sio_pkg::NUM_TIMERS];
  logic [sio_pkg::TIMER_W-1:0] cnt_dec [sio_pkg::NUM_TIMERS];
  logic [sio_pkg::LFSR_W-1:0] lfsr_q, lfsr_d, lfsr_next;
  logic [7:0] rd;

  assign lfsr_next = sio_pkg::lfsr_step8(lfsr_q);

  always_comb begin
    for (int t = 0; t < sio_pkg::NUM_TIMERS; t++) begin
      reload[t]  = sio_pkg::reload_value(freq_q[sio_pkg::TIMER_FREQ_IDX[t]]);
      cnt_pre[t] = (timer_q[t] == '0) ? reload[t] : timer_q[t];
      cnt_dec[t] = cnt_pre[t] - {{(sio_pkg::TIMER_W-1){1'b0}}, 1'b1};
    end
  end

  always_comb begin
    freq_d        = freq_q;
    chan_ctrl_d   = chan_ctrl_q;
    audio_ctrl_d  = audio_ctrl_q;
    serial_ctrl_d = serial_ctrl_q;
    irq_enable_d  = irq_enable_q;
    irq_pend_d    = irq_pend_q;
    status_d      = status_q;
    key_code_d    = key_code_q;
    serout_d      = serout_q;
    delay_d       = delay_q;
    timer_d       = timer_q;
    lfsr_d        = lfsr_q;
    rd            = 8'h00;

    unique case (sio_pkg::opcode_e'(item_i.opcode))
      sio_pkg::OP_READ: begin
        if (!item_i.reg_addr[3]) begin
          rd = sio_pkg::POT_ABSENT;
        end else begin
          unique case (item_i.reg_addr)
            sio_pkg::ADDR_KEY_CODE: rd = key_code_q;
            sio_pkg::ADDR_RANDOM: begin
              lfsr_d = lfsr_next;
              rd     = lfsr_next[7:0];
            end
            sio_pkg::ADDR_SEROUT: rd = 8'h00;
            sio_pkg::ADDR_IRQ:    rd = ~irq_pend_q;
            sio_pkg::ADDR_SERIAL: rd = status_q;
            default:              rd = 8'hFF;
          endcase
        end
      end
      sio_pkg::OP_WRITE: begin
        if (!item_i.reg_addr[3]) begin
          if (!item_i.reg_addr[0]) freq_d[item_i.reg_addr[2:1]] = item_i.data_in;
          else chan_ctrl_d[item_i.reg_addr[2:1]] = item_i.data_in;
        end else begin
          unique case (item_i.reg_addr)
            sio_pkg::ADDR_AUDIO_CTRL: audio_ctrl_d = item_i.data_in;
            sio_pkg::ADDR_TIMER_RST:  timer_d = reload;
            sio_pkg::ADDR_STAT_RST:   status_d = status_q | sio_pkg::STATUS_RESET_BITS;
            sio_pkg::ADDR_SEROUT: begin
              serout_d = item_i.data_in;
              irq_pend_d[sio_pkg::PEND_SERDONE] = 1'b0;
              irq_pend_d[sio_pkg::PEND_SEROUT]  = 1'b1;
              delay_d = sio_pkg::SERIAL_DELAY_TICKS;
            end
            sio_pkg::ADDR_IRQ: begin
              irq_enable_d = item_i.data_in;
              irq_pend_d   = irq_pend_q & item_i.data_in;
            end
            sio_pkg::ADDR_SERIAL: serial_ctrl_d = item_i.data_in;
            default: ;
          endcase
        end
      end
      sio_pkg::OP_TICK: begin
        if (delay_q != 3'd0) begin
          delay_d = delay_q - 3'd1;
          if (delay_q == 3'd1) irq_pend_d[sio_pkg::PEND_SERDONE] = 1'b1;
        end
        for (int t = 0; t < sio_pkg::NUM_TIMERS; t++) begin
          if (cnt_dec[t] == '0) begin
            irq_pend_d[t] = 1'b1;
            timer_d[t]    = reload[t];
          end else begin
            timer_d[t]    = cnt_dec[t];
          end
        end
      end
      sio_pkg::OP_KEY_DOWN: begin
        key_code_d = item_i.data_in;
        irq_pend_d[sio_pkg::PEND_KEY]    = 1'b1;
        status_d[sio_pkg::STAT_KEY_DOWN] = 1'b0;
        if (item_i.data_in[sio_pkg::KEY_SHIFT_BIT]) status_d[sio_pkg::STAT_SHIFT] = 1'b0;
      end
      sio_pkg::OP_KEY_UP: begin
        status_d[sio_pkg::STAT_KEY_DOWN] = 1'b1;
        status_d[sio_pkg::STAT_SHIFT]    = 1'b1;
      end
      sio_pkg::OP_BREAK: irq_pend_d[sio_pkg::PEND_BREAK] = 1'b1;
      default: ;
    endcase
  end

  assign result_o.read_data     = rd;
  assign result_o.pending_flags = irq_pend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        freq_q[i]      <= 8'h00;
        chan_ctrl_q[i] <= 8'h00;
      end
      audio_ctrl_q  <= 8'h00;
      serial_ctrl_q <= 8'h00;
      irq_enable_q  <= 8'h00;
      irq_pend_q    <= 8'h00;
      status_q      <= sio_pkg::STATUS_IDLE;
      key_code_q    <= 8'h00;
      serout_q      <= 8'h00;
      delay_q       <= 3'd0;
      for (int t = 0; t < sio_pkg::NUM_TIMERS; t++) timer_q[t] <= '0;
      lfsr_q        <= '0;
    end else if (step_i) begin
      freq_q        <= freq_d;
      chan_ctrl_q   <= chan_ctrl_d;
      audio_ctrl_q  <= audio_ctrl_d;
      serial_ctrl_q <= serial_ctrl_d;
      irq_enable_q  <= irq_enable_d;
      irq_pend_q    <= irq_pend_d;
      status_q      <= status_d;
      key_code_q    <= key_code_d;
      serout_q      <= serout_d;
      delay_q       <= delay_d;
      timer_q       <= timer_d;
      lfsr_q        <= lfsr_d;
    end
  end

endmodule
`default_nettype wire

>>> hdl/sound_io_chip_timers_irq_keyboard.sv
// Top level: input register, state/step core and result register of the
// sound and I/O timer/interrupt/keyboard block. Uses sio_pkg and sio_core.
//
// Each input transaction is one bus access, tick or key event; each yields
// exactly one result transaction carrying the read byte and the pending IRQ
// bits after the step. An accepted transaction is held in the input
// register, then the core step writes its result into the result register
// when that register is empty or being taken, and one item is taken every
// cycle while the output side keeps up. The core state advances only when an
// item moves from the input register into the result register, so
// backpressure on the output side never drops or repeats a step.
`default_nettype none
module sound_io_chip_timers_irq_keyboard (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // [2:0] opcode, [6:3] reg_addr, [14:7] data_in, [15] zero
  input  wire logic [sio_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // [7:0] read_data, [15:8] pending_flags
  output logic [sio_pkg::OUT_TDATA_W-1:0]         m_axis_tdata_o
);

  logic             in_valid_q;
  sio_pkg::item_t   in_item_q;
  logic             out_valid_q;
  sio_pkg::result_t out_res_q;
  sio_pkg::result_t core_res;
  logic             advance;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) in_valid_q <= s_axis_tvalid_i;
      if (advance) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_item_q.opcode   <= s_axis_tdata_i[2:0];
      in_item_q.reg_addr <= s_axis_tdata_i[6:3];
      in_item_q.data_in  <= s_axis_tdata_i[14:7];
    end
    if (advance) out_res_q <= core_res;
  end

  sio_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_item_q),
    .result_o (core_res)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_res_q.pending_flags, out_res_q.read_data};

endmodule
`default_nettype wire

>>> hdl/sio_checker.sv
// Port-level checks for sound_io_chip_timers_irq_keyboard, attached by bind.
// Depends only on the top level's ports.
`default_nettype none
module sio_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [15:0] m_axis_tdata_o
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled output changed");

  // input is only held off while a result waits
  a_ready_bp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without output backpressure");

  // accepted item reaches output once the sink is ready
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) ##1 m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("accepted item did not produce a result");

endmodule

bind sound_io_chip_timers_irq_keyboard sio_checker u_sio_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
`default_nettype wire
